### rtl/tcbdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-channel bus drop framer package
// Buffer sizing, command codes, register indexes and header kinds.
// ----------------------------------------------------------------------------
package tcbdf_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);

	localparam logic [2:0] CMD_LINE      = 3'd0;
	localparam logic [2:0] CMD_READ_A    = 3'd1;
	localparam logic [2:0] CMD_READ_B    = 3'd2;
	localparam logic [2:0] CMD_RELEASE_A = 3'd3;
	localparam logic [2:0] CMD_RELEASE_B = 3'd4;
	localparam logic [2:0] CMD_STAGE     = 3'd5;
	localparam logic [2:0] CMD_COMMIT    = 3'd6;

	localparam logic [2:0] REG_DROP_ID        = 3'd0;
	localparam logic [2:0] REG_ID_MASK        = 3'd1;
	localparam logic [2:0] REG_HEADER_MASK    = 3'd2;
	localparam logic [2:0] REG_TOKEN_PATTERN  = 3'd3;
	localparam logic [2:0] REG_IDLE_PATTERN   = 3'd4;
	localparam logic [2:0] REG_CLOCK_RESET_ID = 3'd5;
	localparam logic [2:0] REG_BLINK_PERIOD   = 3'd6;

	localparam logic [1:0] KIND_A_IDLE  = 2'b00;
	localparam logic [1:0] KIND_B_IDLE  = 2'b01;
	localparam logic [1:0] KIND_A_TOKEN = 2'b10;
	localparam logic [1:0] KIND_B_TOKEN = 2'b11;

	localparam logic [3:0] DROP_ID_MAX = 4'd14;

endpackage
`default_nettype wire

### rtl/tcbdf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framer channel interfaces
// Request channel (commands and line bytes) and response channel.
// ----------------------------------------------------------------------------
interface tcbdf_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] line_byte;
	logic       parity_error;
	logic [7:0] position;
	logic [7:0] stage_byte;

	modport source (output valid, command, line_byte, parity_error, position, stage_byte,
		input ready);
	modport sink (input valid, command, line_byte, parity_error, position, stage_byte,
		output ready);
endinterface

interface tcbdf_rsp_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_first_word;
	logic [7:0]  tx_second_word;
	logic        word_start;
	logic        packet_a_done;
	logic [8:0]  a_length;
	logic [8:0]  b_length;
	logic [7:0]  read_data;
	logic        clear_to_send;
	logic [31:0] time_tick;
	logic        clock_light;
	logic        accepted;

	modport source (output valid, tx_valid, tx_first_word, tx_second_word, word_start,
		packet_a_done, a_length, b_length, read_data, clear_to_send, time_tick,
		clock_light, accepted, input ready);
	modport sink (input valid, tx_valid, tx_first_word, tx_second_word, word_start,
		packet_a_done, a_length, b_length, read_data, clear_to_send, time_tick,
		clock_light, accepted, output ready);
endinterface
`default_nettype wire

### rtl/two_channel_bus_drop_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-channel bus drop framer
// Takes one request per cycle while rsp.ready does not stall the response,
// and returns one response per request: the request is registered while the
// three buffer RAMs are read, then the framing, transmit and command logic
// runs and the response register is loaded. The request register lines up
// with the registered RAM read. Buffer contents are undefined after reset
// and need no clearing pass.
// ----------------------------------------------------------------------------
module two_channel_bus_drop_framer import tcbdf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tcbdf_req_if.sink       req,
	tcbdf_rsp_if.source     rsp,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration
	logic [3:0]  drop_id_q;
	logic [5:0]  id_mask_q, header_mask_q, token_pattern_q, idle_pattern_q, clock_reset_id_q;
	logic [15:0] blink_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_id_q        <= 4'd0;
			id_mask_q        <= 6'd15;
			header_mask_q    <= 6'd63;
			token_pattern_q  <= 6'd48;
			idle_pattern_q   <= 6'd16;
			clock_reset_id_q <= 6'd15;
			blink_period_q   <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DROP_ID: begin
					drop_id_q <= (cfg_data[3:0] > DROP_ID_MAX) ? DROP_ID_MAX : cfg_data[3:0];
				end
				REG_ID_MASK:        id_mask_q        <= cfg_data[5:0];
				REG_HEADER_MASK:    header_mask_q    <= cfg_data[5:0];
				REG_TOKEN_PATTERN:  token_pattern_q  <= cfg_data[5:0];
				REG_IDLE_PATTERN:   idle_pattern_q   <= cfg_data[5:0];
				REG_CLOCK_RESET_ID: clock_reset_id_q <= cfg_data[5:0];
				REG_BLINK_PERIOD:   blink_period_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// state
	logic [7:0]       first_byte_q;
	logic [PTR_W-1:0] a_wptr_q, a_done_q, b_wptr_q, b_done_q, out_len_q, out_rptr_q;
	logic             a_tok_q, b_tok_q, light_q;
	logic [7:0]       credit_q, b_hdr0_q, b_hdr1_q;
	logic [31:0]      tick_q;
	logic [15:0]      blink_q;

	logic [7:0]       first_byte_d;
	logic [PTR_W-1:0] a_wptr_d, a_done_d, b_wptr_d, b_done_d, out_len_d, out_rptr_d;
	logic             a_tok_d, b_tok_d, light_d;
	logic [7:0]       credit_d, b_hdr0_d, b_hdr1_d;
	logic [31:0]      tick_d;
	logic [15:0]      blink_d;

	// request stage
	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] line_byte_s1, position_s1, stage_byte_s1;
	logic       parity_error_s1;

	logic req_fire, s1_fire, out_valid_q;

	assign s1_fire   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_fire;
	assign req_fire  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			command_s1      <= req.command;
			line_byte_s1    <= req.line_byte;
			parity_error_s1 <= req.parity_error;
			position_s1     <= req.position;
			stage_byte_s1   <= req.stage_byte;
		end
	end

	// buffer RAMs with write-to-read forwarding
	logic              a_we, b_we, o_we;
	logic [ADDR_W-1:0] a_waddr, b_waddr, o_waddr;
	logic [7:0]        a_wdata, b_wdata, o_wdata;
	logic [ADDR_W-1:0] a_raddr, b_raddr, o_raddr;
	logic [7:0]        a_ram, b_ram, o_ram;
	logic              a_hit_q, b_hit_q, o_hit_q;
	logic [7:0]        a_byp_q, b_byp_q, o_byp_q;
	logic [7:0]        a_rd, b_rd, o_rd;
	logic [8:0]        req_pos_b;

	assign req_pos_b = {1'b0, req.position} + 9'd2;
	assign a_raddr   = req.position[ADDR_W-1:0];
	assign b_raddr   = req_pos_b[ADDR_W-1:0];
	assign o_raddr   = out_rptr_d[ADDR_W-1:0];

	tcbdf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_a_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(req_fire), .raddr(a_raddr), .rdata(a_ram)
	);
	tcbdf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_b_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.re(req_fire), .raddr(b_raddr), .rdata(b_ram)
	);
	tcbdf_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_o_ram (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.re(req_fire), .raddr(o_raddr), .rdata(o_ram)
	);

	always_ff @(posedge clk) begin
		if (req_fire) begin
			a_hit_q <= a_we && (a_waddr == a_raddr);
			b_hit_q <= b_we && (b_waddr == b_raddr);
			o_hit_q <= o_we && (o_waddr == o_raddr);
			a_byp_q <= a_wdata;
			b_byp_q <= b_wdata;
			o_byp_q <= o_wdata;
		end
	end

	assign a_rd = a_hit_q ? a_byp_q : a_ram;
	assign b_rd = b_hit_q ? b_byp_q : b_ram;
	assign o_rd = o_hit_q ? o_byp_q : o_ram;

	// request processing
	logic [5:0]       hdr, oh;
	logic [7:0]       dat, ob;
	logic             is_line, is_first, is_second, hit_drop, space_now;
	logic             tx_v, ws, adone, acc;
	logic [7:0]       w0, w1, rd;
	logic [PTR_W-1:0] a_base, b_base;
	logic [8:0]       pos_b, pos_o;
	logic [15:0]      blink_inc;

	always_comb begin
		first_byte_d = first_byte_q;
		a_wptr_d     = a_wptr_q;
		a_done_d     = a_done_q;
		a_tok_d      = a_tok_q;
		b_wptr_d     = b_wptr_q;
		b_done_d     = b_done_q;
		b_tok_d      = b_tok_q;
		b_hdr0_d     = b_hdr0_q;
		b_hdr1_d     = b_hdr1_q;
		credit_d     = credit_q;
		out_len_d    = out_len_q;
		out_rptr_d   = out_rptr_q;
		tick_d       = tick_q;
		blink_d      = blink_q;
		light_d      = light_q;
		a_we = 1'b0; a_waddr = '0; a_wdata = '0;
		b_we = 1'b0; b_waddr = '0; b_wdata = '0;
		o_we = 1'b0; o_waddr = '0; o_wdata = '0;
		tx_v = 1'b0; w0 = 8'd0; w1 = 8'd0; ws = 1'b0; adone = 1'b0; acc = 1'b0; rd = 8'd0;
		oh = 6'd0; ob = 8'd0;
		a_base = '0; b_base = '0;

		hdr       = {first_byte_q[6:4], line_byte_s1[6:4]};
		dat       = {first_byte_q[3:0], line_byte_s1[3:0]};
		is_line   = (command_s1 == CMD_LINE) && !parity_error_s1;
		is_first  = is_line && !line_byte_s1[7];
		is_second = is_line && line_byte_s1[7];
		hit_drop  = (hdr & id_mask_q) == {2'b00, drop_id_q};
		space_now = (b_done_q == '0) && (b_wptr_q == '0);
		pos_b     = {1'b0, position_s1} + 9'd2;
		pos_o     = {1'b0, position_s1} + 9'd1;
		blink_inc = blink_q + 16'd1;

		if (valid_s1 && s1_fire) begin
			unique case (command_s1)
				CMD_LINE: begin
					if (is_first) begin
						first_byte_d = line_byte_s1;
						ws           = 1'b1;
						tick_d       = tick_q + 32'd1;
						if (blink_inc >= blink_period_q) begin
							light_d = !light_q;
							blink_d = 16'd0;
						end else begin
							blink_d = blink_inc;
						end
					end else if (is_second) begin
						unique case (hdr[5:4])
							KIND_A_TOKEN: begin
								a_tok_d = 1'b1;
								a_base  = (a_done_q != '0) ? '0 : a_wptr_q;
								if (a_done_q != '0) a_done_d = '0;
								a_wptr_d = a_base;
								if (a_base < PTR_W'(BUFFER_DEPTH)) begin
									a_we     = 1'b1;
									a_waddr  = a_base[ADDR_W-1:0];
									a_wdata  = dat;
									a_wptr_d = a_base + 1'b1;
								end
							end
							KIND_A_IDLE: begin
								if (a_tok_q) begin
									a_done_d = a_wptr_q;
									adone    = 1'b1;
								end
								a_tok_d = 1'b0;
							end
							KIND_B_TOKEN: begin
								b_tok_d = 1'b1;
								b_base  = (b_done_q != '0) ? '0 : b_wptr_q;
								if (b_done_q != '0) b_done_d = '0;
								b_wptr_d = b_base;
								if (b_base < PTR_W'(BUFFER_DEPTH)) begin
									b_we     = 1'b1;
									b_waddr  = b_base[ADDR_W-1:0];
									b_wdata  = dat;
									b_wptr_d = b_base + 1'b1;
									if (b_base == PTR_W'(0)) b_hdr0_d = dat;
									if (b_base == PTR_W'(1)) b_hdr1_d = dat;
								end
							end
							KIND_B_IDLE: begin
								if (b_tok_q) begin
									if (b_wptr_q >= PTR_W'(2) && b_hdr0_q == {4'd0, drop_id_q}) begin
										b_done_d = b_wptr_q;
										credit_d = b_hdr1_q;
									end else begin
										b_done_d = '0;
										b_wptr_d = '0;
									end
								end
								b_tok_d = 1'b0;
							end
							default: ;
						endcase

						if (hit_drop) begin
							if (!hdr[5]) credit_d = dat;
							if (out_len_q != '0) begin
								ob = o_rd;
								oh = header_mask_q & (token_pattern_q | {2'b00, drop_id_q});
							end else begin
								ob = {7'd0, (b_done_d == '0) && (b_wptr_d == '0)};
								oh = header_mask_q & (idle_pattern_q | {2'b00, drop_id_q});
							end
							w0   = {1'b0, oh[5:3], ob[7:4]};
							w1   = {1'b1, oh[2:0], ob[3:0]};
							tx_v = 1'b1;
							if (out_len_q != '0) begin
								if (out_rptr_q + 1'b1 >= out_len_q) begin
									out_rptr_d = '0;
									out_len_d  = '0;
								end else begin
									out_rptr_d = out_rptr_q + 1'b1;
								end
							end
						end else if ((hdr & id_mask_q) == clock_reset_id_q) begin
							tick_d = 32'd0;
						end
					end
				end
				CMD_READ_A: begin
					if ({1'b0, position_s1} < 9'(a_done_q) && {1'b0, position_s1} < 9'(BUFFER_DEPTH))
						rd = a_rd;
				end
				CMD_READ_B: begin
					if (pos_b < 9'(b_done_q) && pos_b < 9'(BUFFER_DEPTH)) rd = b_rd;
				end
				CMD_RELEASE_A: begin
					if (a_done_q != '0) begin
						a_done_d = '0;
						a_wptr_d = '0;
					end
				end
				CMD_RELEASE_B: begin
					if (b_done_q != '0) begin
						b_done_d = '0;
						b_wptr_d = '0;
					end
				end
				CMD_STAGE: begin
					if (out_len_q == '0 && pos_o < 9'(BUFFER_DEPTH)) begin
						o_we    = 1'b1;
						o_waddr = pos_o[ADDR_W-1:0];
						o_wdata = stage_byte_s1;
						acc     = 1'b1;
					end
				end
				CMD_COMMIT: begin
					if (out_len_q == '0 && credit_q != 8'd0) begin
						o_we       = 1'b1;
						o_waddr    = '0;
						o_wdata    = {7'd0, space_now};
						credit_d   = credit_q - 8'd1;
						out_len_d  = (pos_o > 9'(BUFFER_DEPTH)) ? PTR_W'(BUFFER_DEPTH)
							: PTR_W'(pos_o);
						out_rptr_d = '0;
						acc        = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_byte_q <= 8'd0;
			a_wptr_q     <= '0;
			a_done_q     <= '0;
			a_tok_q      <= 1'b0;
			b_wptr_q     <= '0;
			b_done_q     <= '0;
			b_tok_q      <= 1'b0;
			b_hdr0_q     <= 8'd0;
			b_hdr1_q     <= 8'd0;
			credit_q     <= 8'd0;
			out_len_q    <= '0;
			out_rptr_q   <= '0;
			tick_q       <= 32'd0;
			blink_q      <= 16'd0;
			light_q      <= 1'b0;
		end else begin
			first_byte_q <= first_byte_d;
			a_wptr_q     <= a_wptr_d;
			a_done_q     <= a_done_d;
			a_tok_q      <= a_tok_d;
			b_wptr_q     <= b_wptr_d;
			b_done_q     <= b_done_d;
			b_tok_q      <= b_tok_d;
			b_hdr0_q     <= b_hdr0_d;
			b_hdr1_q     <= b_hdr1_d;
			credit_q     <= credit_d;
			out_len_q    <= out_len_d;
			out_rptr_q   <= out_rptr_d;
			tick_q       <= tick_d;
			blink_q      <= blink_d;
			light_q      <= light_d;
		end
	end

	// response register
	logic        tx_v_q, ws_q, adone_q, cts_q, light_out_q, acc_q;
	logic [7:0]  w0_q, w1_q, rd_q;
	logic [8:0]  alen_q, blen_q;
	logic [31:0] tick_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			tx_v_q      <= tx_v;
			w0_q        <= w0;
			w1_q        <= w1;
			ws_q        <= ws;
			adone_q     <= adone;
			alen_q      <= 9'(a_done_d);
			blen_q      <= 9'(b_done_d);
			rd_q        <= rd;
			cts_q       <= (out_len_d == '0) && (credit_d != 8'd0);
			tick_out_q  <= tick_d;
			light_out_q <= light_d;
			acc_q       <= acc;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.tx_valid       = tx_v_q;
	assign rsp.tx_first_word  = w0_q;
	assign rsp.tx_second_word = w1_q;
	assign rsp.word_start     = ws_q;
	assign rsp.packet_a_done  = adone_q;
	assign rsp.a_length       = alen_q;
	assign rsp.b_length       = blen_q;
	assign rsp.read_data      = rd_q;
	assign rsp.clear_to_send  = cts_q;
	assign rsp.time_tick      = tick_out_q;
	assign rsp.clock_light    = light_out_q;
	assign rsp.accepted       = acc_q;

endmodule
`default_nettype wire

### rtl/tcbdf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcbdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/tcbdf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Framer port checker
// Response consistency and stall behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module tcbdf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_first_word,
	input wire logic [7:0] tx_second_word,
	input wire logic       word_start,
	input wire logic       packet_a_done,
	input wire logic [7:0] read_data,
	input wire logic       accepted
);

	a_idle_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tx_valid |-> tx_first_word == 8'd0 && tx_second_word == 8'd0)
		else $error("reply words set without a transmit");

	a_word_marks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tx_valid |-> !tx_first_word[7] && tx_second_word[7])
		else $error("reply word marks wrong");

	a_accept_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && accepted |-> !tx_valid && !word_start && !packet_a_done
			&& read_data == 8'd0)
		else $error("accepted request shows line activity");

	a_start_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && word_start |-> !tx_valid && !packet_a_done)
		else $error("first byte shows second byte activity");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_first_word)
			&& $stable(read_data))
		else $error("stalled response changed");

endmodule

bind two_channel_bus_drop_framer tcbdf_checker u_tcbdf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.tx_valid(rsp.tx_valid),
	.tx_first_word(rsp.tx_first_word),
	.tx_second_word(rsp.tx_second_word),
	.word_start(rsp.word_start),
	.packet_a_done(rsp.packet_a_done),
	.read_data(rsp.read_data),
	.accepted(rsp.accepted)
);
`default_nettype wire
